// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the frame builder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every rising clock edge outside reset
`define PCFB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property failed");

// condition must never be seen outside reset
`define PCFB_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define PCFB_ASSERT(lbl, clk, rst_n, prop)
`define PCFB_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/core/pcfb_pkg.sv =====
package pcfb_pkg;

  // input item modes
  localparam logic [2:0] MODE_RD_BITS  = 3'd0;
  localparam logic [2:0] MODE_RD_WORDS = 3'd1;
  localparam logic [2:0] MODE_WR_BITS  = 3'd2;
  localparam logic [2:0] MODE_WR_WORDS = 3'd3;
  localparam logic [2:0] MODE_RUN      = 3'd4;
  localparam logic [2:0] MODE_STOP     = 3'd5;
  localparam logic [2:0] MODE_NAME     = 3'd6;
  localparam logic [2:0] MODE_PAYLOAD  = 3'd7;

  // device kinds
  localparam logic [3:0] DEV_D  = 4'd0;
  localparam logic [3:0] DEV_R  = 4'd1;
  localparam logic [3:0] DEV_TN = 4'd2;
  localparam logic [3:0] DEV_TS = 4'd3;
  localparam logic [3:0] DEV_CN = 4'd4;
  localparam logic [3:0] DEV_CS = 4'd5;
  localparam logic [3:0] DEV_X  = 4'd6;
  localparam logic [3:0] DEV_Y  = 4'd7;
  localparam logic [3:0] DEV_M  = 4'd8;
  localparam logic [3:0] DEV_S  = 4'd9;

  // subheaders of the control commands
  localparam logic [7:0] SUB_RUN  = 8'h13;
  localparam logic [7:0] SUB_STOP = 8'h14;
  localparam logic [7:0] SUB_NAME = 8'h15;

  // nibble flags of a bit payload byte
  localparam logic [7:0] BIT_FIRST  = 8'h10;
  localparam logic [7:0] BIT_SECOND = 8'h01;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMER   = 2'd1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0]  STATION_RESET = 8'hFF;
  localparam logic [15:0] TIMER_RESET   = 16'd10;

  // depth of the job queue between front and back
  localparam int unsigned JOB_DEPTH = 4;

  // byte positions inside a batch frame
  localparam logic [3:0] BYTE_STATION = 4'd1;
  localparam logic [3:0] BYTE_TIM_LO  = 4'd2;
  localparam logic [3:0] BYTE_TIM_HI  = 4'd3;
  localparam logic [3:0] BYTE_START0  = 4'd4;
  localparam logic [3:0] BYTE_START1  = 4'd5;
  localparam logic [3:0] BYTE_START2  = 4'd6;
  localparam logic [3:0] BYTE_START3  = 4'd7;
  localparam logic [3:0] BYTE_CODE_LO = 4'd8;
  localparam logic [3:0] BYTE_CODE_HI = 4'd9;
  localparam logic [3:0] BYTE_COUNT   = 4'd10;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  device_kind;
    logic [31:0] start_number;
    logic [7:0]  point_count;
    logic [15:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       rejected;
  } out_item_t;

  typedef enum logic [2:0] {
    JOB_REJECT,
    JOB_SHORT,
    JOB_BATCH,
    JOB_BITS,
    JOB_WORD
  } job_kind_e;

  // one serializing job; first holds the subheader, the batch command byte or the bit payload byte
  typedef struct packed {
    job_kind_e   kind;
    logic [7:0]  first;
    logic [31:0] start_number;
    logic [15:0] code;
    logic [7:0]  point_count;
    logic [15:0] data_word;
    logic        last;
  } job_t;

  function automatic logic is_bit_device(logic [3:0] kind);
    return (kind == DEV_TS) || (kind == DEV_CS) || (kind == DEV_X) ||
           (kind == DEV_Y) || (kind == DEV_M) || (kind == DEV_S);
  endfunction

  function automatic logic [15:0] device_code(logic [3:0] kind);
    logic [15:0] code;
    case (kind)
      DEV_D:   code = 16'h4420;
      DEV_R:   code = 16'h5220;
      DEV_TN:  code = 16'h544E;
      DEV_TS:  code = 16'h5453;
      DEV_CN:  code = 16'h434E;
      DEV_CS:  code = 16'h4353;
      DEV_X:   code = 16'h5820;
      DEV_Y:   code = 16'h5920;
      DEV_M:   code = 16'h4D20;
      DEV_S:   code = 16'h5320;
      default: code = 16'h0000;
    endcase
    return code;
  endfunction

  function automatic logic [3:0] job_len(job_kind_e kind);
    logic [3:0] len;
    case (kind)
      JOB_SHORT: len = 4'd4;
      JOB_BATCH: len = 4'd12;
      JOB_WORD:  len = 4'd2;
      default:   len = 4'd1;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/pcfb_front.sv =====
module pcfb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  pcfb_pkg::in_item_t item_i,
  output pcfb_pkg::job_t     job_o
);

  logic       pending_q, pending_d;
  logic       is_bits_q, is_bits_d;
  logic [7:0] left_q, left_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      is_bits_q <= 1'b0;
      left_q    <= 8'd0;
    end else if (accept_i) begin
      pending_q <= pending_d;
      is_bits_q <= is_bits_d;
      left_q    <= left_d;
    end
  end

  always_comb begin
    logic       more;
    logic [7:0] bits_byte;
    pending_d = pending_q;
    is_bits_d = is_bits_q;
    left_d    = left_q;
    more      = 1'b0;
    bits_byte = item_i.data_word[0] ? pcfb_pkg::BIT_FIRST : 8'h00;

    job_o.kind         = pcfb_pkg::JOB_REJECT;
    job_o.first        = item_i.mode == pcfb_pkg::MODE_RUN  ? pcfb_pkg::SUB_RUN :
                         item_i.mode == pcfb_pkg::MODE_STOP ? pcfb_pkg::SUB_STOP :
                         item_i.mode == pcfb_pkg::MODE_NAME ? pcfb_pkg::SUB_NAME :
                         {5'd0, item_i.mode};
    job_o.start_number = item_i.start_number;
    job_o.code         = pcfb_pkg::device_code(item_i.device_kind);
    job_o.point_count  = item_i.point_count;
    job_o.data_word    = item_i.data_word;
    job_o.last         = 1'b1;

    if (item_i.mode == pcfb_pkg::MODE_PAYLOAD) begin
      if (pending_q) begin
        if (is_bits_q) begin
          if (left_q >= 8'd2) begin
            if (item_i.data_word[1]) begin
              bits_byte = bits_byte | pcfb_pkg::BIT_SECOND;
            end
            left_d = left_q - 8'd2;
          end else begin
            // odd final point, second half padded with zero
            left_d = 8'd0;
          end
          job_o.kind  = pcfb_pkg::JOB_BITS;
          job_o.first = bits_byte;
        end else begin
          left_d     = left_q - 8'd1;
          job_o.kind = pcfb_pkg::JOB_WORD;
        end
        job_o.last = (left_d == 8'd0);
        if (left_d == 8'd0) begin
          pending_d = 1'b0;
          is_bits_d = 1'b0;
        end
      end
    end else begin
      // any command abandons an unfinished write frame
      pending_d = 1'b0;
      is_bits_d = 1'b0;
      left_d    = 8'd0;
      if (item_i.mode == pcfb_pkg::MODE_RUN || item_i.mode == pcfb_pkg::MODE_STOP ||
          item_i.mode == pcfb_pkg::MODE_NAME) begin
        job_o.kind = pcfb_pkg::JOB_SHORT;
      end else if ((item_i.mode == pcfb_pkg::MODE_RD_BITS ||
                    item_i.mode == pcfb_pkg::MODE_WR_BITS) &&
                   !pcfb_pkg::is_bit_device(item_i.device_kind)) begin
        job_o.kind = pcfb_pkg::JOB_REJECT;
      end else begin
        more = (item_i.mode == pcfb_pkg::MODE_WR_BITS ||
                item_i.mode == pcfb_pkg::MODE_WR_WORDS) && (item_i.point_count != 8'd0);
        job_o.kind = pcfb_pkg::JOB_BATCH;
        job_o.last = !more;
        if (more) begin
          pending_d = 1'b1;
          is_bits_d = (item_i.mode == pcfb_pkg::MODE_WR_BITS);
          left_d    = item_i.point_count;
        end
      end
    end
  end

endmodule

// ===== rtl/core/pcfb_job_fifo.sv =====
`include "assert_macros.svh"

module pcfb_job_fifo #(
  parameter int unsigned Depth = pcfb_pkg::JOB_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  pcfb_pkg::job_t  wr_job_i,
  output logic            full_o,
  input  logic            rd_i,
  output logic            valid_o,
  output pcfb_pkg::job_t  rd_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pcfb_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o   = (cnt_q == CntW'(Depth));
  assign valid_o  = (cnt_q != '0);
  assign rd_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (rd_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `PCFB_NEVER(a_no_write_when_full, clk_i, rst_ni, wr_i && full_o)
  `PCFB_NEVER(a_no_read_when_empty, clk_i, rst_ni, rd_i && !valid_o)

endmodule

// ===== rtl/core/pcfb_back.sv =====
`include "assert_macros.svh"

module pcfb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         station_i,
  input  logic [15:0]        timer_i,
  input  logic               job_valid_i,
  input  pcfb_pkg::job_t     job_i,
  output logic               job_done_o,
  output pcfb_pkg::out_item_t out_item_o,
  output logic               empty,
  input  logic               pop
);

  logic [3:0]          idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  pcfb_pkg::out_item_t out_q, out_d;
  logic                out_free, emit, last_byte;
  logic [7:0]          head_byte, sel_byte;

  assign out_free   = !out_valid_q || pop;
  assign emit       = job_valid_i && out_free;
  assign last_byte  = (idx_q == pcfb_pkg::job_len(job_i.kind) - 4'd1);
  assign job_done_o = emit && last_byte;

  // bytes 0..3 are common to short and batch frames
  always_comb begin
    case (idx_q)
      4'd0:                    head_byte = job_i.first;
      pcfb_pkg::BYTE_STATION:  head_byte = station_i;
      pcfb_pkg::BYTE_TIM_LO:   head_byte = timer_i[7:0];
      pcfb_pkg::BYTE_TIM_HI:   head_byte = timer_i[15:8];
      pcfb_pkg::BYTE_START0:   head_byte = job_i.start_number[7:0];
      pcfb_pkg::BYTE_START1:   head_byte = job_i.start_number[15:8];
      pcfb_pkg::BYTE_START2:   head_byte = job_i.start_number[23:16];
      pcfb_pkg::BYTE_START3:   head_byte = job_i.start_number[31:24];
      pcfb_pkg::BYTE_CODE_LO:  head_byte = job_i.code[7:0];
      pcfb_pkg::BYTE_CODE_HI:  head_byte = job_i.code[15:8];
      pcfb_pkg::BYTE_COUNT:    head_byte = job_i.point_count;
      default:                 head_byte = 8'h00;
    endcase
  end

  always_comb begin
    case (job_i.kind)
      pcfb_pkg::JOB_SHORT,
      pcfb_pkg::JOB_BATCH: sel_byte = head_byte;
      pcfb_pkg::JOB_BITS:  sel_byte = job_i.first;
      pcfb_pkg::JOB_WORD:  sel_byte = idx_q[0] ? job_i.data_word[15:8] : job_i.data_word[7:0];
      default:             sel_byte = 8'h00;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop;
    if (emit) begin
      idx_d              = last_byte ? 4'd0 : idx_q + 4'd1;
      out_valid_d        = 1'b1;
      out_d.out_byte     = sel_byte;
      out_d.frame_end    = last_byte && job_i.last;
      out_d.rejected     = (job_i.kind == pcfb_pkg::JOB_REJECT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  `PCFB_ASSERT(a_idx_in_frame, clk_i, rst_ni,
      !job_valid_i || (idx_q < pcfb_pkg::job_len(job_i.kind)))
  `PCFB_ASSERT(a_reject_is_blank, clk_i, rst_ni,
      empty || !out_q.rejected || (out_q.frame_end && out_q.out_byte == 8'h00))
  `PCFB_ASSERT(a_idx_rewinds, clk_i, rst_ni, job_done_o |=> (idx_q == 4'd0))
  `PCFB_ASSERT(a_emit_fills_output, clk_i, rst_ni, emit |=> !empty)

endmodule

// ===== rtl/core/plc_command_frame_builder.sv =====
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+---------------------------
// item in   | in        | push / full               | in_item_i (in_item_t)
// result    | out       | empty / pop               | out_item_o (out_item_t)
// config    | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one frame byte leaves per cycle while the consumer pops, set by the back end
// serializer: a batch command makes 12 bytes, a short command 4, a word payload 2,
// a bit payload or a rejection 1; items enter every cycle while the queue has room.
// the output register is refilled in the cycle it is popped; a stalled
// consumer holds the back end and the front takes items until the job queue fills.
// reset clears the write-frame state, the job queue and the output register;
// station number resets to 255 and monitor time to 10.
module plc_command_frame_builder #(
  parameter int unsigned JobDepth = pcfb_pkg::JOB_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  pcfb_pkg::in_item_t                  in_item_i,
  output logic                                empty,
  input  logic                                pop,
  output pcfb_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pcfb_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pcfb_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [7:0]     station_q;
  logic [15:0]    timer_q;
  logic           accept, job_valid, job_done;
  pcfb_pkg::job_t new_job, head_job;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q <= pcfb_pkg::STATION_RESET;
      timer_q   <= pcfb_pkg::TIMER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == pcfb_pkg::CFG_STATION) begin
        station_q <= cfg_data_i[7:0];
      end else if (cfg_index_i == pcfb_pkg::CFG_TIMER) begin
        timer_q <= cfg_data_i[15:0];
      end
    end
  end

  pcfb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .job_o    (new_job)
  );

  pcfb_job_fifo #(
    .Depth (JobDepth)
  ) u_job_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (accept),
    .wr_job_i (new_job),
    .full_o   (full),
    .rd_i     (job_done),
    .valid_o  (job_valid),
    .rd_job_o (head_job)
  );

  pcfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .station_i   (station_q),
    .timer_i     (timer_q),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .job_done_o  (job_done),
    .out_item_o  (out_item_o),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

// ===== test/tb_plc_command_frame_builder.sv =====
`timescale 1ns / 1ps

module tb_plc_command_frame_builder;

  typedef struct packed {
    pcfb_pkg::in_item_t  item;
    logic                typed;
    pcfb_pkg::out_item_t first;
  } dir_row_t;

  localparam pcfb_pkg::out_item_t NO_BYTE = '{8'h00, 1'b1, 1'b1};
  localparam int DIR_N = 24;

  // stimulus rows; first holds the leading result where it is plain to see
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{'{pcfb_pkg::MODE_PAYLOAD,  pcfb_pkg::DEV_D,  32'h0,        8'd0,  16'h0000},
      1'b1, NO_BYTE},
    '{'{pcfb_pkg::MODE_RUN,      pcfb_pkg::DEV_D,  32'h0,        8'd0,  16'h0000},
      1'b1, '{pcfb_pkg::SUB_RUN, 1'b0, 1'b0}},
    '{'{pcfb_pkg::MODE_STOP,     4'hF,             32'hFFFFFFFF, 8'hFF, 16'hFFFF},
      1'b1, '{pcfb_pkg::SUB_STOP, 1'b0, 1'b0}},
    '{'{pcfb_pkg::MODE_NAME,     pcfb_pkg::DEV_M,  32'h5A5A5A5A, 8'h81, 16'h8001},
      1'b1, '{pcfb_pkg::SUB_NAME, 1'b0, 1'b0}},
    '{'{pcfb_pkg::MODE_RD_BITS,  pcfb_pkg::DEV_D,  32'h0,        8'd1,  16'h0000},
      1'b1, NO_BYTE},
    '{'{pcfb_pkg::MODE_RD_BITS,  pcfb_pkg::DEV_X,  32'h0,        8'd0,  16'h0000}, 1'b0, '0},
    '{'{pcfb_pkg::MODE_RD_WORDS, pcfb_pkg::DEV_D,  32'hFFFFFFFF, 8'hFF, 16'h0000}, 1'b0, '0},
    '{'{pcfb_pkg::MODE_RD_WORDS, 4'hF,             32'h12345678, 8'd1,  16'h0000}, 1'b0, '0},
    '{'{pcfb_pkg::MODE_WR_BITS,  pcfb_pkg::DEV_M,  32'h00000100, 8'd3,  16'h0000}, 1'b0, '0},
    '{'{pcfb_pkg::MODE_PAYLOAD,  pcfb_pkg::DEV_D,  32'h0,        8'd0,  16'h0003}, 1'b0, '0},
    '{'{pcfb_pkg::MODE_PAYLOAD,  pcfb_pkg::DEV_D,  32'h0,        8'd0,  16'hFFFD}, 1'b0, '0},
    '{'{pcfb_pkg::MODE_WR_WORDS, pcfb_pkg::DEV_R,  32'h00010000, 8'd2,  16'h0000}, 1'b0, '0},
    '{'{pcfb_pkg::MODE_PAYLOAD,  pcfb_pkg::DEV_D,  32'h0,        8'd0,  16'hFFFF}, 1'b0, '0},
    '{'{pcfb_pkg::MODE_PAYLOAD,  pcfb_pkg::DEV_D,  32'h0,        8'd0,  16'h0000}, 1'b0, '0},
    '{'{pcfb_pkg::MODE_WR_WORDS, pcfb_pkg::DEV_S,  32'h00000020, 8'd0,  16'h0000}, 1'b0, '0},
    '{'{pcfb_pkg::MODE_PAYLOAD,  pcfb_pkg::DEV_D,  32'h0,        8'd0,  16'h1234},
      1'b1, NO_BYTE},
    '{'{pcfb_pkg::MODE_WR_BITS,  pcfb_pkg::DEV_Y,  32'h00000007, 8'd4,  16'h0000}, 1'b0, '0},
    '{'{pcfb_pkg::MODE_PAYLOAD,  pcfb_pkg::DEV_D,  32'h0,        8'd0,  16'h0002}, 1'b0, '0},
    '{'{pcfb_pkg::MODE_RD_WORDS, pcfb_pkg::DEV_CN, 32'h80000001, 8'd2,  16'h0000}, 1'b0, '0},
    '{'{pcfb_pkg::MODE_PAYLOAD,  pcfb_pkg::DEV_D,  32'h0,        8'd0,  16'h0003},
      1'b1, NO_BYTE},
    '{'{pcfb_pkg::MODE_WR_WORDS, 4'hC,             32'hCAFE0001, 8'hFF, 16'h0000}, 1'b0, '0},
    '{'{pcfb_pkg::MODE_PAYLOAD,  pcfb_pkg::DEV_D,  32'h0,        8'd0,  16'hA55A}, 1'b0, '0},
    '{'{pcfb_pkg::MODE_WR_BITS,  pcfb_pkg::DEV_TN, 32'h0,        8'd2,  16'h0000},
      1'b1, NO_BYTE},
    '{'{pcfb_pkg::MODE_PAYLOAD,  pcfb_pkg::DEV_D,  32'h0,        8'd0,  16'h0001},
      1'b1, NO_BYTE}
  };

  localparam logic [15:0] DEV_CODES [10] = '{
    16'h4420, 16'h5220, 16'h544E, 16'h5453, 16'h434E,
    16'h4353, 16'h5820, 16'h5920, 16'h4D20, 16'h5320
  };
  localparam logic [3:0] BIT_KINDS [6] = '{
    pcfb_pkg::DEV_TS, pcfb_pkg::DEV_CS, pcfb_pkg::DEV_X,
    pcfb_pkg::DEV_Y, pcfb_pkg::DEV_M, pcfb_pkg::DEV_S
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  pcfb_pkg::in_item_t   in_item_i;
  logic                 empty;
  logic                 pop;
  pcfb_pkg::out_item_t  out_item_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [pcfb_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [pcfb_pkg::CFG_DATA_W-1:0] cfg_data_i;

  plc_command_frame_builder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // own copy of the frame builder state
  logic [7:0]  station_r;
  logic [15:0] timer_r;
  logic        wr_pending;
  logic        wr_bits;
  logic [7:0]  wr_left;

  pcfb_pkg::out_item_t frame_bytes_q [$];
  int        err_cnt;
  int        items_sent;
  bit        gaps_on;
  int        pop_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void add_byte(logic [7:0] b, logic last, logic rej);
    pcfb_pkg::out_item_t e;
    e.out_byte  = b;
    e.frame_end = last;
    e.rejected  = rej;
    frame_bytes_q = {frame_bytes_q, e};
  endfunction

  function automatic logic bit_device(logic [3:0] kind);
    logic hit;
    hit = 1'b0;
    foreach (BIT_KINDS[i]) if (BIT_KINDS[i] == kind) hit = 1'b1;
    return hit;
  endfunction

  // expected frame bytes for one accepted item
  function automatic void build_frame_bytes(pcfb_pkg::in_item_t it);
    logic [7:0]  b;
    logic [7:0]  sub;
    logic [15:0] code;
    logic        more;
    if (it.mode == pcfb_pkg::MODE_PAYLOAD) begin
      if (!wr_pending) begin
        add_byte(8'h00, 1'b1, 1'b1);
        return;
      end
      if (wr_bits) begin
        b = it.data_word[0] ? pcfb_pkg::BIT_FIRST : 8'h00;
        if (wr_left >= 8'd2) begin
          if (it.data_word[1]) b = b | pcfb_pkg::BIT_SECOND;
          wr_left = wr_left - 8'd2;
        end else begin
          // odd last point, second half padded with zero
          wr_left = 8'd0;
        end
        add_byte(b, wr_left == 8'd0, 1'b0);
      end else begin
        wr_left = wr_left - 8'd1;
        add_byte(it.data_word[7:0], 1'b0, 1'b0);
        add_byte(it.data_word[15:8], wr_left == 8'd0, 1'b0);
      end
      if (wr_left == 8'd0) begin
        wr_pending = 1'b0;
        wr_bits = 1'b0;
      end
      return;
    end
    // any command drops an unfinished write frame
    wr_pending = 1'b0;
    wr_bits = 1'b0;
    wr_left = 8'd0;
    if (it.mode == pcfb_pkg::MODE_RUN || it.mode == pcfb_pkg::MODE_STOP ||
        it.mode == pcfb_pkg::MODE_NAME) begin
      case (it.mode)
        pcfb_pkg::MODE_RUN:  sub = pcfb_pkg::SUB_RUN;
        pcfb_pkg::MODE_STOP: sub = pcfb_pkg::SUB_STOP;
        default:             sub = pcfb_pkg::SUB_NAME;
      endcase
      add_byte(sub, 1'b0, 1'b0);
      add_byte(station_r, 1'b0, 1'b0);
      add_byte(timer_r[7:0], 1'b0, 1'b0);
      add_byte(timer_r[15:8], 1'b1, 1'b0);
      return;
    end
    if ((it.mode == pcfb_pkg::MODE_RD_BITS || it.mode == pcfb_pkg::MODE_WR_BITS) &&
        !bit_device(it.device_kind)) begin
      add_byte(8'h00, 1'b1, 1'b1);
      return;
    end
    code = (it.device_kind < 4'd10) ? DEV_CODES[it.device_kind] : 16'h0000;
    more = (it.mode == pcfb_pkg::MODE_WR_BITS || it.mode == pcfb_pkg::MODE_WR_WORDS) &&
           it.point_count != 8'd0;
    add_byte({5'd0, it.mode}, 1'b0, 1'b0);
    add_byte(station_r, 1'b0, 1'b0);
    add_byte(timer_r[7:0], 1'b0, 1'b0);
    add_byte(timer_r[15:8], 1'b0, 1'b0);
    for (int i = 0; i < 4; i++) add_byte(it.start_number[8*i +: 8], 1'b0, 1'b0);
    add_byte(code[7:0], 1'b0, 1'b0);
    add_byte(code[15:8], 1'b0, 1'b0);
    add_byte(it.point_count, 1'b0, 1'b0);
    add_byte(8'h00, !more, 1'b0);
    if (more) begin
      wr_pending = 1'b1;
      wr_bits = (it.mode == pcfb_pkg::MODE_WR_BITS);
      wr_left = it.point_count;
    end
  endfunction

  // called at a falling edge; push stays high on return
  task automatic send_item(input pcfb_pkg::in_item_t it, input logic typed,
                           input pcfb_pkg::out_item_t first);
    int gap;
    int at;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    at = frame_bytes_q.size();
    build_frame_bytes(it);
    if (typed) frame_bytes_q[at] = first;
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (frame_bytes_q.size() != 0) @(negedge clk_i);
  endtask

  // leaves cfg_valid_i high; the caller lowers it
  task automatic cfg_write(input logic [pcfb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pcfb_pkg::CFG_DATA_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == pcfb_pkg::CFG_STATION) station_r = d[7:0];
    else if (idx == pcfb_pkg::CFG_TIMER) timer_r = d;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] st, input logic [15:0] tm);
    wait_drained();
    cfg_write(pcfb_pkg::CFG_STATION, st);
    cfg_write(pcfb_pkg::CFG_TIMER, tm);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic pcfb_pkg::in_item_t rand_item();
    pcfb_pkg::in_item_t it;
    it.mode = 3'($urandom_range(0, 7));
    it.device_kind = 4'($urandom_range(0, 15));
    it.start_number = $urandom;
    it.point_count = 8'($urandom_range(0, 255));
    it.data_word = 16'($urandom);
    return it;
  endfunction

  task automatic random_traffic(input int n);
    int stop_at;
    int pick;
    int need;
    int k;
    pcfb_pkg::in_item_t it;
    pcfb_pkg::in_item_t pl;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      it = rand_item();
      pl = rand_item();
      pl.mode = pcfb_pkg::MODE_PAYLOAD;
      if (pick < 55) begin
        // write frame followed by its payload, sometimes cut short or with one extra payload item
        it.mode = $urandom_range(0, 1) ? pcfb_pkg::MODE_WR_BITS : pcfb_pkg::MODE_WR_WORDS;
        if (it.mode == pcfb_pkg::MODE_WR_BITS && $urandom_range(0, 7) != 0)
          it.device_kind = BIT_KINDS[$urandom_range(0, 5)];
        k = $urandom_range(0, 19);
        it.point_count = (k == 0) ? 8'd0 :
                         (k == 1) ? 8'($urandom_range(8, 255)) : 8'($urandom_range(1, 7));
        send_item(it, 1'b0, '0);
        need = (it.mode == pcfb_pkg::MODE_WR_BITS) ? (it.point_count + 1) / 2 :
               it.point_count;
        if (need > 6 || $urandom_range(0, 4) == 0)
          need = $urandom_range(0, (need > 6) ? 6 : need);
        for (int i = 0; i < need; i++) begin
          pl.data_word = 16'($urandom);
          send_item(pl, 1'b0, '0);
        end
        if ($urandom_range(0, 9) == 0) send_item(pl, 1'b0, '0);
      end else if (pick < 90) begin
        it.mode = 3'($urandom_range(0, 6));
        send_item(it, 1'b0, '0);
      end else begin
        send_item(pl, 1'b0, '0);
      end
    end
  endtask

  // result side: pop with random stall bursts
  initial begin
    pop = 1'b0;
    pop_hold = 0;
    forever begin
      @(negedge clk_i);
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        pop_hold = $urandom_range(0, 8);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    pcfb_pkg::out_item_t exp_b;
    if (rst_ni && pop && !empty) begin
      if (frame_bytes_q.size() == 0) begin
        $error("unexpected transfer: out_byte %h frame_end %b rejected %b",
               out_item_o.out_byte, out_item_o.frame_end, out_item_o.rejected);
        err_cnt++;
      end else begin
        exp_b = frame_bytes_q.pop_front();
        if (out_item_o.out_byte !== exp_b.out_byte) begin
          $error("out_byte: expected %h, got %h", exp_b.out_byte, out_item_o.out_byte);
          err_cnt++;
        end
        if (out_item_o.frame_end !== exp_b.frame_end) begin
          $error("frame_end: expected %b, got %b", exp_b.frame_end, out_item_o.frame_end);
          err_cnt++;
        end
        if (out_item_o.rejected !== exp_b.rejected) begin
          $error("rejected: expected %b, got %b", exp_b.rejected, out_item_o.rejected);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = pcfb_pkg::CFG_STATION;
    cfg_data_i = '0;
    err_cnt = 0;
    items_sent = 0;
    gaps_on = 1'b1;
    station_r = pcfb_pkg::STATION_RESET;
    timer_r = pcfb_pkg::TIMER_RESET;
    wr_pending = 1'b0;
    wr_bits = 1'b0;
    wr_left = 8'd0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_N; i++)
      send_item(DIR_TAB[i].item, DIR_TAB[i].typed, DIR_TAB[i].first);
    push <= 1'b0;

    set_config(16'h0000, 16'h0000);
    random_traffic(52);
    push <= 1'b0;

    set_config(16'h00FF, 16'hFFFF);
    random_traffic(52);
    push <= 1'b0;

    // full rate to the end
    gaps_on = 1'b0;
    set_config(16'($urandom), 16'($urandom));
    random_traffic(52);
    push <= 1'b0;

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
